/* rtl/igr_pkg.sv */
// Shared types and codes for the int8 GEMM requantize unit.
package igr_pkg;

  typedef enum logic [1:0] {
    REQ_WEIGHT = 2'd0,
    REQ_PARAM  = 2'd1,
    REQ_ACT    = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  localparam logic [1:0] CFG_INPUT_LENGTH   = 2'd0;
  localparam logic [1:0] CFG_OUTPUT_COUNT   = 2'd1;
  localparam logic [1:0] CFG_OUT_ZERO_POINT = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MAC_RD,
    ST_MAC,
    ST_MAC_LAST,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SHIFT,
    ST_EMIT
  } state_e;

endpackage

/* rtl/int8_gemm_requantize_unit.sv */
// Top level of the int8 fully connected layer with per-channel requantization.
//
//  channel | direction | tdata fields (low bit first)                     | side band
//  s_axis  | in        | req_type, out_index, in_index, value, bias_value, | tlast = last_in_row
//          |           | multiplier, shift_amount (93 bits, 96 on bus)    |
//  m_axis  | out       | out_value, out_channel (14 bits, 16 on bus)      | tlast = last
//  cfg     | in        | cfg_we_i, cfg_idx_i, cfg_wdata_i                 | -
//
// Set-up and plain activation transfers are taken only while the sequencer is idle. The
// transfer that ends a row starts the sequencer: per channel, ST_LOAD and ST_MAC_RD
// address the memories and load the bias, then input_length products pass through the
// single 8x8 multiply-accumulate unit, ST_MUL_LO and ST_MUL_HI pass through the shared
// 32x16 multiplier for the high product half, ST_SHIFT does the rounding shift and
// ST_EMIT presents the result.
// The sink stalls only the emit step.
// Reset clears control state, configuration and the accumulator; the product and result
// registers and the stores stay undefined until written, so no clearing pass runs.
module int8_gemm_requantize_unit #(
  parameter int IN_MAX  = 256,
  parameter int OUT_MAX = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // req_type[1:0], out_index[7:2], in_index[15:8],
                                     // value[23:16], bias_value[55:24],
                                     // multiplier[87:56], shift_amount[92:88], zero fill
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // out_value[7:0], out_channel[13:8], zero fill
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [8:0]  cfg_wdata_i
);
  // tdata of s_axis: [1:0] req_type, [7:2] out_index, [15:8] in_index,
  // [23:16] value, [55:24] bias_value, [87:56] multiplier, [92:88] shift_amount;
  // the bus is 93 bits padded to 96.
  localparam int IW = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
  localparam int OW = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
  localparam int LW = $clog2(IN_MAX + 1);
  localparam int CW = $clog2(OUT_MAX + 1);

  logic [95:0] sd;
  assign sd = s_axis_tdata;

  logic [1:0]         req;
  logic [5:0]         oi;
  logic [7:0]         ii;
  logic signed [7:0]  val;
  logic signed [31:0] bias_in, mul_in;
  logic [4:0]         sh_in;
  assign req     = sd[1:0];
  assign oi      = sd[7:2];
  assign ii      = sd[15:8];
  assign val     = sd[23:16];
  assign bias_in = sd[55:24];
  assign mul_in  = sd[87:56];
  assign sh_in   = sd[92:88];

  // Configuration registers
  logic [8:0]        in_len_q;
  logic [6:0]        out_cnt_q;
  logic signed [7:0] zp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_len_q  <= 9'd256;
      out_cnt_q <= 7'd64;
      zp_q      <= 8'sd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        igr_pkg::CFG_INPUT_LENGTH:   in_len_q  <= cfg_wdata_i;
        igr_pkg::CFG_OUTPUT_COUNT:   out_cnt_q <= cfg_wdata_i[6:0];
        igr_pkg::CFG_OUT_ZERO_POINT: zp_q      <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Clamp the lengths to 1..max
  logic [LW-1:0] len_c;
  logic [CW-1:0] cnt_c;
  always_comb begin
    if (in_len_q == 9'd0) len_c = LW'(1);
    else if (32'(in_len_q) > IN_MAX) len_c = LW'(IN_MAX);
    else len_c = LW'(in_len_q);
    if (out_cnt_q == 7'd0) cnt_c = CW'(1);
    else if (32'(out_cnt_q) > OUT_MAX) cnt_c = CW'(OUT_MAX);
    else cnt_c = CW'(out_cnt_q);
  end

  // Stores
  logic signed [7:0]  wmem [OUT_MAX*IN_MAX];
  logic signed [7:0]  rmem [IN_MAX];
  logic signed [31:0] bmem [OUT_MAX];
  logic signed [31:0] smem [OUT_MAX];
  logic [4:0]         hmem [OUT_MAX];

  logic acc_in;
  assign acc_in = s_axis_tvalid && s_axis_tready;

  logic oi_ok, ii_ok;
  assign oi_ok = 32'(oi) < OUT_MAX;
  assign ii_ok = 32'(ii) < IN_MAX;

  igr_pkg::state_e state_q, state_d;
  logic [OW-1:0] ch_q, ch_d;
  logic [IW-1:0] k_q, k_d;
  logic [LW-1:0] kn_q, kn_d;

  always_ff @(posedge clk_i) begin
    if (acc_in && igr_pkg::req_e'(req) == igr_pkg::REQ_WEIGHT && oi_ok && ii_ok)
      wmem[(OW+IW)'(OW'(oi)) * (OW+IW)'(IN_MAX) + (OW+IW)'(IW'(ii))] <= val;
    if (acc_in && igr_pkg::req_e'(req) == igr_pkg::REQ_ACT && ii_ok)
      rmem[IW'(ii)] <= val;
    if (acc_in && igr_pkg::req_e'(req) == igr_pkg::REQ_PARAM && oi_ok) begin
      bmem[OW'(oi)] <= bias_in;
      smem[OW'(oi)] <= mul_in;
      hmem[OW'(oi)] <= sh_in;
    end
  end

  // Registered memory reads
  logic signed [7:0]  w_rd_q, a_rd_q;
  logic signed [31:0] b_rd_q, s_rd_q;
  logic [4:0]         h_rd_q;
  always_ff @(posedge clk_i) begin
    w_rd_q <= wmem[(OW+IW)'(ch_q) * (OW+IW)'(IN_MAX) + (OW+IW)'(k_q)];
    a_rd_q <= rmem[k_q];
    b_rd_q <= bmem[ch_q];
    s_rd_q <= smem[ch_q];
    h_rd_q <= hmem[ch_q];
  end

  // Datapath registers
  logic [31:0]        acc_q, acc_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [7:0]  res_q, res_d;

  // Shared 32x16 multiplier: acc times one half of the multiplier
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] mul_p;
  assign mul_a = {acc_q[31], acc_q};
  assign mul_b = (state_q == igr_pkg::ST_MUL_LO) ? {1'b0, s_rd_q[15:0]}
                                                 : {s_rd_q[31], s_rd_q[31:16]};
  assign mul_p = 50'(mul_a * mul_b);

  // Rounding shift, zero point and saturation on the high half
  logic signed [32:0] hi;
  logic signed [33:0] q, rnd;
  logic signed [34:0] v;
  always_comb begin
    hi  = {prod_q[63], prod_q[63:32]};
    q   = 34'(hi >>> h_rd_q);
    rnd = (h_rd_q == 5'd0) ? 34'sd0 : 34'({33'd0, hi[h_rd_q - 5'd1]});
    v   = 35'(q) + 35'(rnd) + 35'(zp_q);
  end

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    k_d     = k_q;
    kn_d    = kn_q;
    acc_d   = acc_q;
    prod_d  = prod_q;
    res_d   = res_q;
    case (state_q)
      igr_pkg::ST_IDLE: begin
        if (acc_in && igr_pkg::req_e'(req) == igr_pkg::REQ_ACT && s_axis_tlast) begin
          ch_d = '0;
          state_d = igr_pkg::ST_LOAD;
        end
      end
      igr_pkg::ST_LOAD: begin
        k_d = '0;
        kn_d = LW'(1);
        state_d = igr_pkg::ST_MAC_RD;
      end
      igr_pkg::ST_MAC_RD: begin
        // reads for k=0 in flight; a one-entry row goes straight to the last add
        acc_d = b_rd_q;
        if (kn_q == len_c) state_d = igr_pkg::ST_MAC_LAST;
        else begin
          k_d = k_q + IW'(1);
          kn_d = kn_q + LW'(1);
          state_d = igr_pkg::ST_MAC;
        end
      end
      igr_pkg::ST_MAC: begin
        acc_d = acc_q + 32'(w_rd_q * a_rd_q);
        if (kn_q == len_c) state_d = igr_pkg::ST_MAC_LAST;
        else begin
          k_d = k_q + IW'(1);
          kn_d = kn_q + LW'(1);
        end
      end
      igr_pkg::ST_MAC_LAST: begin
        acc_d = acc_q + 32'(w_rd_q * a_rd_q);
        state_d = igr_pkg::ST_MUL_LO;
      end
      igr_pkg::ST_MUL_LO: begin
        prod_d = 64'(mul_p);
        state_d = igr_pkg::ST_MUL_HI;
      end
      igr_pkg::ST_MUL_HI: begin
        prod_d = prod_q + (64'(mul_p) <<< 16);
        state_d = igr_pkg::ST_SHIFT;
      end
      igr_pkg::ST_SHIFT: begin
        if (v > 35'sd127) res_d = 8'sd127;
        else if (v < -35'sd128) res_d = -8'sd128;
        else res_d = v[7:0];
        state_d = igr_pkg::ST_EMIT;
      end
      igr_pkg::ST_EMIT: begin
        if (m_axis_tready) begin
          if (CW'(ch_q) + CW'(1) == cnt_c) state_d = igr_pkg::ST_IDLE;
          else begin
            ch_d = ch_q + OW'(1);
            state_d = igr_pkg::ST_LOAD;
          end
        end
      end
      default: state_d = igr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= igr_pkg::ST_IDLE;
      ch_q    <= '0;
      k_q     <= '0;
      kn_q    <= '0;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      k_q     <= k_d;
      kn_q    <= kn_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    res_q  <= res_d;
  end

  assign s_axis_tready = (state_q == igr_pkg::ST_IDLE);
  assign m_axis_tvalid = (state_q == igr_pkg::ST_EMIT);
  assign m_axis_tdata  = {2'b00, 6'(ch_q), res_q};
  assign m_axis_tlast  = (CW'(ch_q) + CW'(1) == cnt_c);

  // Accept and emit never overlap
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("accept during emit");
  // A held result keeps its channel
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  // Channel never passes the clamped count
  a_ch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(ch_q) < cnt_c || state_q == igr_pkg::ST_IDLE) else $error("channel overrun");

endmodule
